### rtl/core/pixel_log_linear_tone_map_macros.svh
// Assertion helpers, used inside modules that have clk and rst_n.
`ifndef PIXEL_LOG_LINEAR_TONE_MAP_MACROS_SVH
`define PIXEL_LOG_LINEAR_TONE_MAP_MACROS_SVH

// Same-cycle implication.
`define PLLTM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plltm same-cycle check failed");

// Next-cycle implication.
`define PLLTM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plltm next-cycle check failed");

`endif

### rtl/core/plltm_pkg.sv
package plltm_pkg;

  localparam int COUNT_BITS      = 32;
  localparam int IN_COUNT_BITS   = 32;
  localparam int LOG_TABLE_DEPTH = 64;
  localparam int IDX_BITS        = $clog2(LOG_TABLE_DEPTH);
  localparam int FRAC_BITS       = 16;
  localparam int LEVEL_BITS      = 8;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 8'hff;

  localparam int PED_FRAC_BITS   = 8;
  localparam int PED_BITS        = 40;
  localparam int LIN_GAIN_BITS   = 32;
  localparam int OFS_BITS        = 23;
  localparam int LOG_GAIN_BITS   = 24;

  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = PED_BITS;

  localparam logic [LIN_GAIN_BITS-1:0] LIN_GAIN_RESET = 32'd65536;
  localparam logic [LOG_GAIN_BITS-1:0] LOG_GAIN_RESET = 24'd2097152;

  // positive difference width
  localparam int D_RAW_BITS = (COUNT_BITS + PED_FRAC_BITS > PED_BITS - 1) ?
                              COUNT_BITS + PED_FRAC_BITS : PED_BITS - 1;
  localparam int D_BITS     = D_RAW_BITS + 1;
  localparam int DIFF_BITS  = D_BITS + 1;
  localparam int M_BITS     = $clog2(D_BITS);

  // linear path
  localparam int LIN_D_BITS    = 32;
  localparam int LIN_SHIFT     = 24;
  localparam int LIN_PROD_BITS = LIN_D_BITS + LIN_GAIN_BITS;

  // log path: log2(256) bias, Q6.16
  localparam int LOG_BIAS      = 8;
  localparam int L_BITS        = M_BITS + 1 + FRAC_BITS;
  localparam int T_BITS        = ((L_BITS > OFS_BITS) ? L_BITS : OFS_BITS) + 1;
  localparam int TMAG_BITS     = T_BITS - 1;
  localparam int LOG_SHIFT     = 32;
  localparam int LOG_PROD_BITS = TMAG_BITS + LOG_GAIN_BITS;

  // pipeline stages
  localparam int NUM_STAGES = 5;
  localparam int ST_SUB     = 0;
  localparam int ST_LOD     = 1;
  localparam int ST_SHIFT   = 2;
  localparam int ST_TERM    = 3;
  localparam int ST_OUT     = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LOG_MODE   = 3'd0,
    REG_PEDESTAL   = 3'd1,
    REG_LIN_GAIN   = 3'd2,
    REG_LOG_OFFSET = 3'd3,
    REG_LOG_GAIN   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                             log_mode;
    logic signed [PED_BITS-1:0]       pedestal;
    logic [LIN_GAIN_BITS-1:0]         lin_gain;
    logic signed [OFS_BITS-1:0]       log_offset;
    logic [LOG_GAIN_BITS-1:0]         log_gain;
  } cfg_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

  typedef struct packed {
    logic                  pos;
    logic                  log_mode;
    logic [M_BITS-1:0]     m;
    logic [IDX_BITS-1:0]   idx;
    logic [LEVEL_BITS-1:0] lin_level;
  } norm_t;

  // log2(1 + i/DEPTH) fraction table, squaring method in Q2.30
  localparam int X_FRAC = 30;

  typedef logic [FRAC_BITS-1:0] frac_tab_t [LOG_TABLE_DEPTH];

  function automatic frac_tab_t build_frac_tab();
    frac_tab_t             tab;
    logic [63:0]           x;
    logic [FRAC_BITS-1:0]  r;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      x = (64'd1 << X_FRAC) + ((64'(i) << X_FRAC) / LOG_TABLE_DEPTH);
      r = '0;
      for (int b = 0; b < FRAC_BITS; b++) begin
        x = (x * x) >> X_FRAC;
        if (x >= (64'd1 << (X_FRAC + 1))) begin
          r = {r[FRAC_BITS-2:0], 1'b1};
          x = x >> 1;
        end else begin
          r = {r[FRAC_BITS-2:0], 1'b0};
        end
      end
      tab[i] = r;
    end
    return tab;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage

### rtl/core/pixel_log_linear_tone_map.sv
// Stages: subtract, leading-one detect with linear multiply, normalize shift,
// log term, log multiply. Throughput: one item per cycle while out_stall is
// low; each stage advances when the next is free, so bubbles close up and a
// stalled result holds while upstream keeps filling.
// Reset: clears all stage valid bits and loads register defaults; no clear pass.
module pixel_log_linear_tone_map (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [plltm_pkg::IN_COUNT_BITS-1:0]    in_pixel_count,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [plltm_pkg::LEVEL_BITS-1:0]       out_level,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [plltm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [plltm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  plltm_pkg::cfg_t       cfg;
  plltm_pkg::pipe_ctrl_t ctrl;
  plltm_pkg::norm_t      norm;

  plltm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  plltm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  plltm_norm u_norm (
    .clk         (clk),
    .pixel_count (in_pixel_count[plltm_pkg::COUNT_BITS-1:0]),
    .cfg         (cfg),
    .ctrl        (ctrl),
    .norm        (norm)
  );

  plltm_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .norm  (norm),
    .cfg   (cfg),
    .ctrl  (ctrl),
    .level (out_level)
  );

endmodule

### rtl/core/plltm_cfg.sv
`include "pixel_log_linear_tone_map_macros.svh"

module plltm_cfg (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [plltm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [plltm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output plltm_pkg::cfg_t                        cfg
);

  plltm_pkg::cfg_t cfg_r, cfg_nxt;
  logic            wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (plltm_pkg::cfg_reg_t'(cfg_index))
        plltm_pkg::REG_LOG_MODE:   cfg_nxt.log_mode   = cfg_data[0];
        plltm_pkg::REG_PEDESTAL:   cfg_nxt.pedestal   =
          $signed(cfg_data[plltm_pkg::PED_BITS-1:0]);
        plltm_pkg::REG_LIN_GAIN:   cfg_nxt.lin_gain   =
          cfg_data[plltm_pkg::LIN_GAIN_BITS-1:0];
        plltm_pkg::REG_LOG_OFFSET: cfg_nxt.log_offset =
          $signed(cfg_data[plltm_pkg::OFS_BITS-1:0]);
        plltm_pkg::REG_LOG_GAIN:   cfg_nxt.log_gain   =
          cfg_data[plltm_pkg::LOG_GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.log_mode   <= 1'b0;
      cfg_r.pedestal   <= '0;
      cfg_r.lin_gain   <= plltm_pkg::LIN_GAIN_RESET;
      cfg_r.log_offset <= '0;
      cfg_r.log_gain   <= plltm_pkg::LOG_GAIN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  `PLLTM_ASSERT_NXT(a_mode_write, wr && (cfg_index == plltm_pkg::REG_LOG_MODE), cfg_r.log_mode == $past(cfg_data[0]))

endmodule

### rtl/core/plltm_ctrl.sv
`include "pixel_log_linear_tone_map_macros.svh"

module plltm_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  output plltm_pkg::pipe_ctrl_t   ctrl
);

  localparam int N = plltm_pkg::NUM_STAGES;

  logic [N-1:0] valid_r, valid_nxt, rdy, vin;

  always_comb begin
    rdy[N-1] = !valid_r[N-1] || !out_stall;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
    vin[0] = in_valid;
    for (int k = 1; k < N; k++) begin
      vin[k] = valid_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      valid_nxt[k] = rdy[k] ? vin[k] : valid_r[k];
    end
  end

  assign ctrl.load = rdy & vin;
  assign in_stall  = !rdy[0];
  assign out_valid = valid_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  `PLLTM_ASSERT_IMP(a_full_stalls_input, (&valid_r) && out_stall, in_stall)
  `PLLTM_ASSERT_NXT(a_first_stage_held, valid_r[0] && !rdy[1], valid_r[0])

endmodule

### rtl/core/plltm_norm.sv
module plltm_norm (
  input  logic                                clk,
  input  logic [plltm_pkg::COUNT_BITS-1:0]    pixel_count,
  input  plltm_pkg::cfg_t                     cfg,
  input  plltm_pkg::pipe_ctrl_t               ctrl,
  output plltm_pkg::norm_t                    norm
);

  localparam int D_BITS    = plltm_pkg::D_BITS;
  localparam int DIFF_BITS = plltm_pkg::DIFF_BITS;
  localparam int M_BITS    = plltm_pkg::M_BITS;
  localparam int LB        = plltm_pkg::LEVEL_BITS;
  localparam int LDB       = plltm_pkg::LIN_D_BITS;
  localparam int LPB       = plltm_pkg::LIN_PROD_BITS;
  localparam int LSH       = plltm_pkg::LIN_SHIFT;
  localparam int IB        = plltm_pkg::IDX_BITS;

  // stage: subtract
  logic signed [DIFF_BITS-1:0] diff;
  logic                        pos;
  logic [D_BITS-1:0]           d0_nxt, d0_r;
  logic                        mode0_r;

  always_comb begin
    diff = $signed({{(DIFF_BITS - plltm_pkg::COUNT_BITS - plltm_pkg::PED_FRAC_BITS){1'b0}},
                    pixel_count, {plltm_pkg::PED_FRAC_BITS{1'b0}}})
         - DIFF_BITS'(cfg.pedestal);
    pos    = !diff[DIFF_BITS-1] && (diff != '0);
    d0_nxt = pos ? diff[D_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[plltm_pkg::ST_SUB]) begin
      d0_r    <= d0_nxt;
      mode0_r <= cfg.log_mode;
    end
  end

  // stage: leading one and linear product
  logic [M_BITS-1:0]   m1_nxt, m1_r;
  logic [LPB-1:0]      prod;
  logic [LB-1:0]       lin1_nxt, lin1_r;
  logic [D_BITS-1:0]   d1_r;
  logic                pos1_r, mode1_r;

  always_comb begin
    m1_nxt = '0;
    for (int i = 0; i < D_BITS; i++) begin
      if (d0_r[i]) m1_nxt = M_BITS'(i);
    end
    prod = LPB'(d0_r[LDB-1:0]) * LPB'(cfg.lin_gain);
    if (cfg.lin_gain == '0) begin
      lin1_nxt = '0;
    end else if ((|d0_r[D_BITS-1:LDB]) || (|prod[LPB-1:LSH+LB])) begin
      lin1_nxt = plltm_pkg::LEVEL_MAX;
    end else begin
      lin1_nxt = prod[LSH +: LB];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[plltm_pkg::ST_LOD]) begin
      d1_r    <= d0_r;
      m1_r    <= m1_nxt;
      pos1_r  <= |d0_r;
      mode1_r <= mode0_r;
      lin1_r  <= lin1_nxt;
    end
  end

  // stage: normalize and pick table index
  logic [D_BITS-1:0]   nrm;
  logic [IB-1:0]       idx2_r;
  logic [M_BITS-1:0]   m2_r;
  logic                pos2_r, mode2_r;
  logic [LB-1:0]       lin2_r;

  assign nrm = d1_r << (M_BITS'(D_BITS - 1) - m1_r);

  always_ff @(posedge clk) begin
    if (ctrl.load[plltm_pkg::ST_SHIFT]) begin
      idx2_r  <= nrm[D_BITS-2 -: IB];
      m2_r    <= m1_r;
      pos2_r  <= pos1_r;
      mode2_r <= mode1_r;
      lin2_r  <= lin1_r;
    end
  end

  assign norm.pos       = pos2_r;
  assign norm.log_mode  = mode2_r;
  assign norm.m         = m2_r;
  assign norm.idx       = idx2_r;
  assign norm.lin_level = lin2_r;

endmodule

### rtl/core/plltm_scale.sv
`include "pixel_log_linear_tone_map_macros.svh"

module plltm_scale (
  input  logic                                clk,
  input  logic                                rst_n,
  input  plltm_pkg::norm_t                    norm,
  input  plltm_pkg::cfg_t                     cfg,
  input  plltm_pkg::pipe_ctrl_t               ctrl,
  output logic [plltm_pkg::LEVEL_BITS-1:0]    level
);

  localparam int M_BITS = plltm_pkg::M_BITS;
  localparam int TB     = plltm_pkg::T_BITS;
  localparam int TMB    = plltm_pkg::TMAG_BITS;
  localparam int LB     = plltm_pkg::LEVEL_BITS;
  localparam int PB     = plltm_pkg::LOG_PROD_BITS;
  localparam int SH     = plltm_pkg::LOG_SHIFT;

  // stage: log term minus offset
  logic [plltm_pkg::FRAC_BITS-1:0]    frac;
  logic signed [M_BITS:0]             int_part;
  logic signed [plltm_pkg::L_BITS-1:0] lval;
  logic signed [TB-1:0]               t;
  logic                               tpos;
  logic [TMB-1:0]                     t3_r;
  logic                               tpos3_r, pos3_r, mode3_r;
  logic [LB-1:0]                      lin3_r;

  always_comb begin
    frac     = plltm_pkg::FRAC_TAB[norm.idx];
    int_part = $signed({1'b0, norm.m}) - $signed((M_BITS + 1)'(plltm_pkg::LOG_BIAS));
    lval     = $signed({int_part, frac});
    t        = TB'(lval) - TB'(cfg.log_offset);
    tpos     = !t[TB-1] && (t != '0);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[plltm_pkg::ST_TERM]) begin
      t3_r    <= t[TMB-1:0];
      tpos3_r <= norm.pos && tpos;
      pos3_r  <= norm.pos;
      mode3_r <= norm.log_mode;
      lin3_r  <= norm.lin_level;
    end
  end

  // stage: log gain, saturate, select
  logic [PB-1:0] prod;
  logic [LB-1:0] level_nxt, level_r;

  always_comb begin
    prod = PB'(t3_r) * PB'(cfg.log_gain);
    if (!mode3_r) begin
      level_nxt = lin3_r;
    end else if (!tpos3_r) begin
      level_nxt = '0;
    end else if (|prod[PB-1:SH+LB]) begin
      level_nxt = plltm_pkg::LEVEL_MAX;
    end else begin
      level_nxt = prod[SH +: LB];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[plltm_pkg::ST_OUT]) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

  `PLLTM_ASSERT_NXT(a_nonpos_zero, ctrl.load[plltm_pkg::ST_OUT] && !pos3_r, level_r == '0)

endmodule

### sim/tb_pixel_log_linear_tone_map.sv
`timescale 1ns / 100ps

module tb_pixel_log_linear_tone_map;
  import plltm_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [IN_COUNT_BITS-1:0] in_pixel_count;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [LEVEL_BITS-1:0]    out_level;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  // shadow copy of the mapping registers
  logic                            log_mode_q;
  logic signed [PED_BITS-1:0]      ped_q;
  logic [LIN_GAIN_BITS-1:0]        lin_gain_q;
  logic signed [OFS_BITS-1:0]      log_ofs_q;
  logic [LOG_GAIN_BITS-1:0]        log_gain_q;
  logic [FRAC_BITS-1:0]            frac_lut [LOG_TABLE_DEPTH];

  logic [LEVEL_BITS-1:0] level_q [$];
  int                    fail_count = 0;
  bit                    tx_idle_en = 1'b0;
  bit                    rx_idle_en = 1'b0;
  int                    rx_hold_req = 0;
  int                    stall_left = 0;

  pixel_log_linear_tone_map i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_count (in_pixel_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_level      (out_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // fraction of log2(1 + i/depth) by repeated squaring in Q2.30
  function automatic logic [FRAC_BITS-1:0] log_frac_entry(int i);
    logic [63:0]          x;
    logic [FRAC_BITS-1:0] bits;
    x = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_DEPTH);
    bits = '0;
    for (int b = FRAC_BITS - 1; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        bits[b] = 1'b1;
        x = x >> 1;
      end
    end
    return bits;
  endfunction

  function automatic logic [LEVEL_BITS-1:0] predict_level(logic [IN_COUNT_BITS-1:0] count);
    longint                diff;
    longint                lg;
    longint                t;
    logic [63:0]           d;
    logic [63:0]           p;
    int                    m;
    logic [IDX_BITS-1:0]   idx;
    diff = longint'({count, 8'd0}) - longint'(ped_q);
    if (diff <= 0) return '0;
    d = diff;
    if (!log_mode_q) begin
      if (lin_gain_q == '0) return '0;
      if (d >= (64'd1 << 32)) return LEVEL_MAX;
      p = (d * lin_gain_q) >> LIN_SHIFT;
    end else begin
      m = 0;
      for (int b = 0; b < 64; b++) if (d[b]) m = b;
      idx = ((d - (64'd1 << m)) * LOG_TABLE_DEPTH) >> m;
      lg = ((longint'(m) - LOG_BIAS) <<< FRAC_BITS) + longint'(frac_lut[idx]);
      t = lg - longint'(log_ofs_q);
      if (t <= 0) return '0;
      p = (64'(t) * log_gain_q) >> LOG_SHIFT;
    end
    return (p > 64'd255) ? LEVEL_MAX : p[LEVEL_BITS-1:0];
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [IN_COUNT_BITS-1:0] pick_count();
    longint base;
    base = longint'(ped_q) >>> PED_FRAC_BITS;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom >> $urandom_range(0, 31);
      7, 8:       return 32'(base + longint'($urandom_range(0, 8)) - 4);
      default:    return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (cfg_reg_t'(idx))
      REG_LOG_MODE:   log_mode_q = data[0];
      REG_PEDESTAL:   ped_q      = data[PED_BITS-1:0];
      REG_LIN_GAIN:   lin_gain_q = data[LIN_GAIN_BITS-1:0];
      REG_LOG_OFFSET: log_ofs_q  = data[OFS_BITS-1:0];
      REG_LOG_GAIN:   log_gain_q = data[LOG_GAIN_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_pixel(input logic [IN_COUNT_BITS-1:0] count);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 1)) ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_pixel_count = count;
    do @(posedge clk); while (in_stall);
    level_q.push_back(predict_level(count));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (level_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    send_pixel('0);
    send_pixel(32'd1);
    send_pixel(32'd255);
    send_pixel(32'd256);
    send_pixel('1);
    drain();
  endtask

  task automatic test_linear_edges();
    write_reg(REG_LIN_GAIN, '0);
    send_pixel(32'd1000);
    drain();
    write_reg(REG_LIN_GAIN, 40'hFF_FFFF_FFFF);
    send_pixel(32'd1);
    drain();
    write_reg(REG_LIN_GAIN, 40'd1);
    send_pixel(32'h00FF_FFFF);
    drain();
    write_reg(REG_LIN_GAIN, 40'hAB_0001_0000);
    send_pixel(32'd3);
    drain();
  endtask

  task automatic test_pedestal();
    write_reg(REG_PEDESTAL, 40'd100 << PED_FRAC_BITS);
    send_pixel(32'd99);
    send_pixel(32'd100);
    send_pixel(32'd101);
    drain();
    write_reg(REG_PEDESTAL, {1'b1, 39'd0});
    send_pixel('0);
    drain();
    write_reg(REG_PEDESTAL, {1'b0, {39{1'b1}}});
    send_pixel('1);
    drain();
    write_reg(REG_PEDESTAL, '0);
    write_reg(REG_LIN_GAIN, 40'(LIN_GAIN_RESET));
  endtask

  task automatic test_log_path();
    // upper bits of the mode write are dropped, bit 0 is clear
    write_reg(REG_LOG_MODE, 40'hFF_FFFF_FFFE);
    send_pixel(32'd5);
    drain();
    write_reg(REG_LOG_MODE, 40'd1);
    send_pixel(32'd1);
    send_pixel(32'd2);
    send_pixel(32'd3);
    send_pixel('1);
    drain();
    write_reg(REG_LOG_OFFSET, 40'(23'h3F_FFFF));
    send_pixel(32'h0001_0000);
    drain();
    write_reg(REG_LOG_OFFSET, 40'(23'h40_0000));
    write_reg(REG_LOG_GAIN, 40'(24'hFF_FFFF));
    send_pixel(32'd1);
    drain();
    write_reg(REG_LOG_GAIN, '0);
    send_pixel(32'd1000);
    drain();
    for (int i = int'(REG_LOG_GAIN) + 1; i < (1 << CFG_IDX_BITS); i++)
      write_reg(CFG_IDX_BITS'(i), {$urandom, 8'($urandom)});
    send_pixel(32'd7);
    drain();
  endtask

  task automatic test_backpressure();
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    rx_hold_req = 80;
    repeat (24) send_pixel(pick_count());
    drain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (3) begin
      repeat (8) send_pixel(pick_count());
      drain();
    end
  endtask

  task automatic randomize_config();
    int ofs;
    write_reg(REG_LOG_MODE, {$urandom, 8'($urandom)});
    case ($urandom_range(0, 5))
      0:       write_reg(REG_PEDESTAL, {1'b1, 39'd0});
      1:       write_reg(REG_PEDESTAL, {1'b0, {39{1'b1}}});
      2, 3:    write_reg(REG_PEDESTAL, 40'($urandom_range(0, 4096)));
      default: write_reg(REG_PEDESTAL, {$urandom, 8'($urandom)});
    endcase
    case ($urandom_range(0, 7))
      0:       write_reg(REG_LIN_GAIN, '0);
      1:       write_reg(REG_LIN_GAIN, '1);
      default: write_reg(REG_LIN_GAIN, {8'($urandom), 32'($urandom >> $urandom_range(0, 31))});
    endcase
    ofs = $urandom_range(0, 24 << FRAC_BITS) - (8 << FRAC_BITS);
    case ($urandom_range(0, 7))
      0:       write_reg(REG_LOG_OFFSET, 40'(23'h40_0000));
      1:       write_reg(REG_LOG_OFFSET, 40'(23'h3F_FFFF));
      default: write_reg(REG_LOG_OFFSET, 40'(ofs));
    endcase
    case ($urandom_range(0, 7))
      0:       write_reg(REG_LOG_GAIN, '0);
      1:       write_reg(REG_LOG_GAIN, 40'(24'hFF_FFFF));
      default: write_reg(REG_LOG_GAIN, 40'($urandom >> $urandom_range(8, 31)));
    endcase
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_BITS'(int'(REG_LOG_GAIN) + $urandom_range(1, 3)),
                {$urandom, 8'($urandom)});
  endtask

  task automatic test_random_mix();
    for (int p = 0; p < 8; p++) begin
      randomize_config();
      tx_idle_en = (p % 4 == 0) || (p % 4 == 1);
      rx_idle_en = (p % 4 == 0) || (p % 4 == 2);
      repeat (40) send_pixel(pick_count());
      drain();
    end
  endtask

  // receiver side: random stall bursts plus a long hold on request
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      stall_left  = rx_hold_req;
      rx_hold_req = 0;
    end
    if (stall_left > 0) begin
      out_stall  = 1'b1;
      stall_left = stall_left - 1;
    end else if (rx_idle_en && $urandom_range(0, 99) < 30) begin
      out_stall  = 1'b1;
      stall_left = idle_len() - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (level_q.size() == 0) begin
        $error("level transfer with no expectation: actual %0d", out_level);
        fail_count++;
      end else if (out_level !== level_q[0]) begin
        $error("level mismatch: expected %0d, actual %0d", level_q[0], out_level);
        fail_count++;
        void'(level_q.pop_front());
      end else begin
        void'(level_q.pop_front());
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) frac_lut[i] = log_frac_entry(i);
    log_mode_q     = 1'b0;
    ped_q          = '0;
    lin_gain_q     = LIN_GAIN_RESET;
    log_ofs_q      = '0;
    log_gain_q     = LOG_GAIN_RESET;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pixel_count = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_linear_edges();
    test_pedestal();
    test_log_path();
    test_backpressure();
    test_random_mix();

    drain();
    repeat (2 * NUM_STAGES) @(negedge clk);
    if (level_q.size() != 0) begin
      $error("%0d level results never arrived", level_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
